// ----- design/mm4_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

  localparam int ELEM_W = 32;
  localparam int POS_W  = 2;

  typedef struct packed {
    logic                     matrix_select;
    logic [POS_W-1:0]         row_index;
    logic [POS_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
    logic                     start_req;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]         out_row;
    logic [POS_W-1:0]         out_col;
    logic signed [ELEM_W-1:0] product_value;
    logic                     overflow;
    logic                     last;
  } out_t;

  // One issued multiply-accumulate step, sent from the sequencer to the datapath.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } mac_ctrl_t;

endpackage

// ----- design/mm4_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mm4_mac.sv -----
// Multiply-accumulate datapath with rounding, saturation and the result register.
module mm4_mac #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mm4_pkg::mac_ctrl_t                ctrl,
  input  logic signed [mm4_pkg::ELEM_W-1:0] a_value,
  input  logic signed [mm4_pkg::ELEM_W-1:0] b_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mm4_pkg::out_t                     out_data
);

  localparam int PROD_W = 2 * mm4_pkg::ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int TOP_LO = FRAC_BITS + mm4_pkg::ELEM_W - 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  mm4_pkg::mac_ctrl_t       ctrl_s1;
  mm4_pkg::mac_ctrl_t       ctrl_s2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  sum;
  logic                     sum_valid;
  logic [mm4_pkg::POS_W-1:0] sum_row;
  logic [mm4_pkg::POS_W-1:0] sum_col;
  logic                     sum_last;
  logic                     move;
  logic [ACC_W-TOP_LO-1:0]  sum_top;
  logic                     fits;
  mm4_pkg::out_t            res;

  // The sum moves on to the result register whenever that register is free or being emptied.
  assign move = sum_valid && (!out_valid || out_ready);

  always_comb begin
    sum_top = sum[ACC_W-1:TOP_LO];
    fits    = (sum_top == '0) || (sum_top == '1);
    res.out_row  = sum_row;
    res.out_col  = sum_col;
    res.last     = sum_last;
    res.overflow = !fits;
    if (fits) begin
      res.product_value = sum[TOP_LO:FRAC_BITS];
    end else if (sum[ACC_W-1]) begin
      res.product_value = {1'b1, {(mm4_pkg::ELEM_W-1){1'b0}}};
    end else begin
      res.product_value = {1'b0, {(mm4_pkg::ELEM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s1   <= '0;
      ctrl_s2   <= '0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ctrl_s1 <= ctrl;
      ctrl_s2 <= ctrl_s1;
      if (ctrl_s2.valid && ctrl_s2.last_k) begin
        sum_valid <= 1'b1;
      end else if (move) begin
        sum_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_value * b_value;
    if (ctrl_s2.valid) begin
      // The rounding constant is folded into the first term of each dot product.
      if (ctrl_s2.first) begin
        acc <= HALF + ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
      if (ctrl_s2.last_k) begin
        sum      <= acc + ACC_W'(prod);
        sum_row  <= ctrl_s2.row;
        sum_col  <= ctrl_s2.col;
        sum_last <= ctrl_s2.last_elem;
      end
    end
    if (move) begin
      out_data <= res;
    end
  end

endmodule

// ----- design/matrix4x4_multiply_core.sv -----
// Top level of the fixed-point matrix multiplier: operand stores and product sequencer.
//
// Input requests each carry one operand element (left or right matrix, row, column,
// signed Q16.16 value). An element with an index not below DIM is dropped. Requests
// are accepted back to back; in_ready is high only while no product is in progress.
// A request with start_req set stores its element and then starts the product.
// The block emits DIM*DIM results in row-major order on the output channel, the final
// one marked by last. Each is the rounded dot product of a left row and a right column,
// saturated to 32 bits with overflow raised when clamped.
// Products are formed by one shared 32x32 multiplier reading one entry of each store
// per cycle, except while a new dot product waits for a free result slot; each result
// is the sum of DIM such terms.
// At most two results are held back when the receiver stalls; the multiplier then
// pauses and resumes with no loss. in_ready returns after the final result is taken and
// none is left. Reset clears the control state only: the stores keep undefined contents
// until written, and every element a product reads must be loaded first.
module matrix4x4_multiply_core #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mm4_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mm4_pkg::out_t out_data
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);
  localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t             state;
  logic [IW-1:0]      i_idx;
  logic [IW-1:0]      j_idx;
  logic [IW-1:0]      k_idx;
  logic [1:0]         outstanding;
  logic               in_accept;
  logic               out_accept;
  logic               issue;
  logic               elem_start;
  logic               in_range;
  logic [AW+1:0]      waddr_wide;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      left_raddr;
  logic [AW-1:0]      right_raddr;
  logic [mm4_pkg::ELEM_W-1:0] left_rdata;
  logic [mm4_pkg::ELEM_W-1:0] right_rdata;
  mm4_pkg::mac_ctrl_t ctrl;

  assign in_ready   = (state == ST_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  // A new dot product starts only when a slot waits for it past the multiplier.
  assign elem_start = (k_idx == '0);
  assign issue      = (state == ST_RUN) && (!elem_start || outstanding < 2'd2);

  always_comb begin
    in_range   = ((AW+2)'(in_data.row_index) < (AW+2)'(DIM)) &&
                 ((AW+2)'(in_data.col_index) < (AW+2)'(DIM));
    waddr_wide = (AW+2)'(in_data.row_index) * (AW+2)'(DIM) + (AW+2)'(in_data.col_index);
    waddr      = waddr_wide[AW-1:0];
    left_raddr  = AW'(i_idx) * AW'(DIM) + AW'(k_idx);
    right_raddr = AW'(k_idx) * AW'(DIM) + AW'(j_idx);
    ctrl.valid     = issue;
    ctrl.first     = elem_start;
    ctrl.last_k    = (k_idx == LAST_IDX);
    ctrl.last_elem = (i_idx == LAST_IDX) && (j_idx == LAST_IDX);
    ctrl.row       = mm4_pkg::POS_W'(i_idx);
    ctrl.col       = mm4_pkg::POS_W'(j_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      i_idx       <= '0;
      j_idx       <= '0;
      k_idx       <= '0;
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'((issue && elem_start) ? 1 : 0)
                                 - 2'(out_accept ? 1 : 0);
      case (state)
        ST_IDLE: begin
          if (in_accept && in_data.start_req) begin
            state <= ST_RUN;
            i_idx <= '0;
            j_idx <= '0;
            k_idx <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (k_idx == LAST_IDX) begin
              k_idx <= '0;
              if (j_idx == LAST_IDX) begin
                j_idx <= '0;
                if (i_idx == LAST_IDX) begin
                  i_idx <= '0;
                  state <= ST_DRAIN;
                end else begin
                  i_idx <= i_idx + 1'b1;
                end
              end else begin
                j_idx <= j_idx + 1'b1;
              end
            end else begin
              k_idx <= k_idx + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (outstanding == '0) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mm4_ram #(
    .WIDTH (mm4_pkg::ELEM_W),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk   (clk),
    .we    (in_accept && in_range && !in_data.matrix_select),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  mm4_ram #(
    .WIDTH (mm4_pkg::ELEM_W),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk   (clk),
    .we    (in_accept && in_range && in_data.matrix_select),
    .waddr (waddr),
    .wdata (in_data.element_value),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  mm4_mac #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .a_value   (left_rdata),
    .b_value   (right_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Loading and computing never overlap, so no result can be pending while requests are taken.
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("result pending while accepting requests");

  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.start_req) |=> !in_ready)
    else $error("request accepted during a product");

  a_slots_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more results in flight than the datapath can hold");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_accept && out_data.last) |=> ##1 (state == ST_IDLE))
    else $error("block did not return to idle after the final result");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix multiplier core.
`timescale 1ns / 100ps

module tb;

  localparam int DIM        = 4;
  localparam int FRAC_BITS  = 16;
  localparam int RAND_ITEMS = 60;     // per random phase, four phases
  localparam int HOLD_LEN   = 150;
  localparam int END_WAIT   = 16;
  localparam int LIMIT      = 200000;

  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  localparam logic signed [67:0] ROUND_HALF = 68'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [67:0] SAT_HI     = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO     = -68'sd2147483648;

  typedef enum logic {FILL_ALL, ONE_ELEM} load_kind_t;

  typedef struct packed {
    load_kind_t  kind;
    logic        sel;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] val;
    logic        start;
    logic        typed;
    logic [31:0] exp_val;
    logic        exp_ovf;
    logic        hold;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mm4_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mm4_pkg::out_t out_data;

  logic signed [31:0] lhs_mat [DIM][DIM];
  logic signed [31:0] rhs_mat [DIM][DIM];
  mm4_pkg::out_t product_q [$];
  mm4_pkg::out_t want_elem;
  dir_row_t dir_tab [DIR_ROWS];

  int errors = 0;
  int cycle_cnt = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  matrix4x4_multiply_core #(
    .DIM      (DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stores the element of an accepted request and, on a start request, queues the
  // sixteen product elements that should follow.
  task automatic accept_request(input mm4_pkg::in_t item, input logic typed,
                                input logic [31:0] tv, input logic tovf);
    logic signed [67:0] acc, a, b;
    mm4_pkg::out_t e;
    int i, j, k;
    if (item.matrix_select == SEL_RIGHT) begin
      rhs_mat[item.row_index][item.col_index] = item.element_value;
    end else begin
      lhs_mat[item.row_index][item.col_index] = item.element_value;
    end
    if (!item.start_req) return;
    for (i = 0; i < DIM; i++) begin
      for (j = 0; j < DIM; j++) begin
        acc = '0;
        for (k = 0; k < DIM; k++) begin
          a = 68'(lhs_mat[i][k]);
          b = 68'(rhs_mat[k][j]);
          acc = acc + a * b;
        end
        // Round to nearest, ties towards plus infinity, then saturate.
        acc = (acc + ROUND_HALF) >>> FRAC_BITS;
        e.out_row = 2'(i);
        e.out_col = 2'(j);
        e.last    = (i == DIM - 1) && (j == DIM - 1);
        if (acc > SAT_HI) begin
          e.product_value = SAT_HI[31:0];
          e.overflow      = 1'b1;
        end else if (acc < SAT_LO) begin
          e.product_value = SAT_LO[31:0];
          e.overflow      = 1'b1;
        end else begin
          e.product_value = acc[31:0];
          e.overflow      = 1'b0;
        end
        if (typed) begin
          e.product_value = tv;
          e.overflow      = tovf;
        end
        product_q.push_back(e);
      end
    end
  endtask

  task automatic send_req(input mm4_pkg::in_t item, input logic typed = 1'b0,
                          input logic [31:0] tv = '0, input logic tovf = 1'b0);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    accept_request(item, typed, tv, tovf);
  endtask

  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          3: v = 32'hFFFFFFFF;
          4: v = 32'h00010000;
          default: v = 32'h00000001;
        endcase
      end
      1, 2: v = $urandom();
      3, 4, 5, 6: v = $urandom_range(32'h000FFFFF) - 32'h00080000;
      default: v = $urandom_range(32'h0FFFFFFF) - 32'h08000000;
    endcase
    return v;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      errors++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (product_q.size() == 0) begin
        $error("unexpected product element at row %0d col %0d",
               out_data.out_row, out_data.out_col);
        errors++;
      end else begin
        want_elem = product_q.pop_front();
        check_field("out_row", 32'(want_elem.out_row), 32'(out_data.out_row));
        check_field("out_col", 32'(want_elem.out_col), 32'(out_data.out_col));
        check_field("product_value", want_elem.product_value, out_data.product_value);
        check_field("overflow", 32'(want_elem.overflow), 32'(out_data.overflow));
        check_field("last", 32'(want_elem.last), 32'(out_data.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    mm4_pkg::in_t item;
    int t, r, c, ph, n;

    // Uniform operands give products that can be worked out by hand: each element
    // is four times the product of the two fill values.
    dir_tab = '{
      '{FILL_ALL, SEL_LEFT,  2'd0, 2'd0, 32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FILL_ALL, SEL_RIGHT, 2'd0, 2'd0, 32'h00010000, 1'b1, 1'b1, 32'h00040000, 1'b0, 1'b0},
      '{FILL_ALL, SEL_LEFT,  2'd0, 2'd0, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FILL_ALL, SEL_RIGHT, 2'd0, 2'd0, 32'h7FFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b1},
      '{FILL_ALL, SEL_LEFT,  2'd0, 2'd0, 32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b1, 1'b0},
      '{FILL_ALL, SEL_RIGHT, 2'd0, 2'd0, 32'h80000000, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b1, 1'b0},
      '{FILL_ALL, SEL_LEFT,  2'd0, 2'd0, 32'h00000001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      // An exact half rounds up, on both sides of zero.
      '{FILL_ALL, SEL_RIGHT, 2'd0, 2'd0, 32'h00002000, 1'b1, 1'b1, 32'h00000001, 1'b0, 1'b0},
      '{FILL_ALL, SEL_LEFT,  2'd0, 2'd0, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h00000000, 1'b0, 1'b0},
      '{FILL_ALL, SEL_RIGHT, 2'd0, 2'd0, 32'h00000000, 1'b1, 1'b1, 32'h00000000, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_LEFT,  2'd0, 2'd0, 32'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_RIGHT, 2'd3, 2'd3, 32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_LEFT,  2'd2, 2'd1, 32'h00018000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_RIGHT, 2'd1, 2'd2, 32'hFFFE8000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_LEFT,  2'd3, 2'd0, 32'h12345678, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_RIGHT, 2'd0, 2'd3, 32'hEDCBA988, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_LEFT,  2'd1, 2'd3, 32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{ONE_ELEM, SEL_RIGHT, 2'd2, 2'd0, 32'h7FFF0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (t = 0; t < DIR_ROWS; t++) begin
      if (dir_tab[t].hold) hold_reqs++;
      if (dir_tab[t].kind == FILL_ALL) begin
        for (r = 0; r < DIM; r++) begin
          for (c = 0; c < DIM; c++) begin
            item.matrix_select = dir_tab[t].sel;
            item.row_index     = 2'(r);
            item.col_index     = 2'(c);
            item.element_value = dir_tab[t].val;
            item.start_req     = dir_tab[t].start && (r == DIM - 1) && (c == DIM - 1);
            send_req(item, dir_tab[t].typed, dir_tab[t].exp_val, dir_tab[t].exp_ovf);
          end
        end
      end else begin
        item.matrix_select = dir_tab[t].sel;
        item.row_index     = dir_tab[t].row;
        item.col_index     = dir_tab[t].col;
        item.element_value = dir_tab[t].val;
        item.start_req     = dir_tab[t].start;
        send_req(item, dir_tab[t].typed, dir_tab[t].exp_val, dir_tab[t].exp_ovf);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 56; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 56; end
        default: begin send_gap_pct = 10; stall_pct = 10; end
      endcase
      for (n = 0; n < RAND_ITEMS; n++) begin
        item.matrix_select = 1'($urandom_range(1));
        item.row_index     = 2'($urandom_range(DIM - 1));
        item.col_index     = 2'($urandom_range(DIM - 1));
        item.element_value = rand_elem();
        item.start_req     = ($urandom_range(11) == 0);
        send_req(item);
      end
    end
    in_valid <= 1'b0;

    while (product_q.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
